/* rtl/core/clt_pkg.sv */
// shared types, codes and constants of the command line tokenizer
// no dependencies; compiled first
package clt_pkg;

	localparam int unsigned DEF_MAX_TOKEN_LEN = 80;
	localparam int unsigned DEF_TOKEN_LIMIT   = 48;
	localparam int unsigned QDEPTH            = 4;
	localparam int unsigned MAX_RES           = 4;

	// result kinds
	localparam logic [1:0] K_CHAR = 2'd0;
	localparam logic [1:0] K_END  = 2'd1;
	localparam logic [1:0] K_LINE = 2'd2;

	// lexer modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_WORD  = 2'd1;
	localparam logic [1:0] MODE_QUOTE = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tbyte;
		logic [5:0] idx;
		logic [6:0] pos;
		logic [5:0] count;
		logic       disc;
		logic       last;
	} res_t;

	// all results caused by one input byte
	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         last;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_sep(logic [7:0] c);
		return (c == 8'h28) || (c == 8'h29) || (c == 8'h5B) || (c == 8'h5D) ||
			(c == 8'h3D) || (c == 8'h2C) || (c == 8'h3C) || (c == 8'h3E) ||
			(c == 8'h7C) || (c == 8'h26) || (c == 8'h23) || (c == 8'h5E) ||
			(c == 8'h25);
	endfunction

endpackage

/* rtl/core/clt_if.sv */
// channel interfaces of the tokenizer: byte input and result output
// no dependencies
interface clt_line_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       line_end;

	modport source (output valid, output in_byte, output line_end, input ready);
	modport sink (input valid, input in_byte, input line_end, output ready);
endinterface

interface clt_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] token_byte;
	logic [5:0] token_index;
	logic [6:0] char_position;
	logic [5:0] token_count;
	logic       line_discarded;
	logic       last_of_run;

	modport source (output valid, output result_kind, output token_byte, output token_index,
		output char_position, output token_count, output line_discarded,
		output last_of_run, input ready);
	modport sink (input valid, input result_kind, input token_byte, input token_index,
		input char_position, input token_count, input line_discarded,
		input last_of_run, output ready);
endinterface

/* rtl/core/clt_front.sv */
// front end: lexes one byte per beat and builds the bundle of results it causes
// depends on clt_pkg and clt_line_if
module clt_front #(
	parameter int unsigned MAX_TOKEN_LEN = clt_pkg::DEF_MAX_TOKEN_LEN,
	parameter int unsigned TOKEN_LIMIT   = clt_pkg::DEF_TOKEN_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	clt_line_if.sink           line_in,
	input  clt_pkg::q_stat_t   q_stat,
	output logic               push,
	output clt_pkg::bundle_t   push_data
);
	import clt_pkg::*;

	localparam int unsigned LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
	localparam int unsigned SEEN_W = $clog2(TOKEN_LIMIT + 1);

	typedef struct packed {
		logic [1:0]         mode;
		logic [LEN_W-1:0]   len;
		logic [SEEN_W-1:0]  seen;
		logic               tm;
		logic               term;
		logic [2:0]         n;
		res_t [MAX_RES-1:0] res;
	} acc_t;

	logic [1:0]        mode_q;
	logic [LEN_W-1:0]  len_q;
	logic [SEEN_W-1:0] seen_q;
	logic              tm_q;
	logic              term_q;
	logic              accept;
	acc_t              acc;

	function automatic acc_t f_put(acc_t a, res_t r);
		a.res[a.n[1:0]] = r;
		a.n = a.n + 3'd1;
		return a;
	endfunction

	function automatic acc_t f_emit(acc_t a, logic [7:0] c);
		res_t r;
		r = '0;
		r.kind  = K_CHAR;
		r.tbyte = c;
		r.idx   = 6'(a.seen);
		r.pos   = 7'(a.len);
		a = f_put(a, r);
		a.len = a.len + LEN_W'(1);
		return a;
	endfunction

	function automatic acc_t f_close(acc_t a);
		res_t r;
		r = '0;
		r.kind = K_END;
		r.idx  = 6'(a.seen);
		r.pos  = 7'(a.len);
		a = f_put(a, r);
		a.seen = a.seen + SEEN_W'(1);
		a.len  = '0;
		a.mode = MODE_IDLE;
		if (a.seen >= SEEN_W'(TOKEN_LIMIT)) a.tm = 1'b1;
		return a;
	endfunction

	function automatic acc_t f_cap(acc_t a);
		if (a.len >= LEN_W'(MAX_TOKEN_LEN)) a = f_close(a);
		return a;
	endfunction

	function automatic acc_t f_start(acc_t a, logic [7:0] c);
		if (is_ws(c)) return a;
		if (is_sep(c)) begin
			a = f_emit(a, c);
			a = f_close(a);
			return a;
		end
		a = f_emit(a, c);
		a.mode = (c == CH_QUOTE) ? MODE_QUOTE : MODE_WORD;
		a = f_cap(a);
		return a;
	endfunction

	always_comb begin
		res_t       done;
		logic [7:0] c;
		c = line_in.in_byte;
		done = '0;
		acc = '0;
		acc.mode = mode_q;
		acc.len  = len_q;
		acc.seen = seen_q;
		acc.tm   = tm_q;
		acc.term = term_q;
		if (!tm_q && !term_q) begin
			if (c == CH_NUL) begin
				if (acc.mode != MODE_IDLE) acc = f_close(acc);
				acc.term = 1'b1;
			end else if (acc.mode == MODE_QUOTE) begin
				acc = f_emit(acc, c);
				if (c == CH_QUOTE) acc = f_close(acc);
				else acc = f_cap(acc);
			end else if (acc.mode == MODE_WORD) begin
				if (is_ws(c)) begin
					acc = f_close(acc);
				end else if (is_sep(c)) begin
					acc = f_close(acc);
					if (!acc.tm) acc = f_start(acc, c);
				end else begin
					acc = f_emit(acc, c);
					acc = f_cap(acc);
				end
			end else begin
				acc = f_start(acc, c);
			end
		end
		if (line_in.line_end) begin
			if (acc.mode != MODE_IDLE && !acc.tm) acc = f_close(acc);
			done.kind  = K_LINE;
			done.count = acc.tm ? 6'd0 : 6'(acc.seen);
			done.disc  = acc.tm;
			acc = f_put(acc, done);
		end
		if (acc.n != 3'd0) acc.res[2'(acc.n - 3'd1)].last = 1'b1;
	end

	assign line_in.ready   = !q_stat.full;
	assign accept          = line_in.valid && line_in.ready;
	assign push            = accept && (acc.n != 3'd0);
	assign push_data.res   = acc.res;
	assign push_data.last  = 2'(acc.n - 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			seen_q <= '0;
			tm_q   <= 1'b0;
			term_q <= 1'b0;
		end else if (accept) begin
			if (line_in.line_end) begin
				mode_q <= MODE_IDLE;
				len_q  <= '0;
				seen_q <= '0;
				tm_q   <= 1'b0;
				term_q <= 1'b0;
			end else begin
				mode_q <= acc.mode;
				len_q  <= acc.len;
				seen_q <= acc.seen;
				tm_q   <= acc.tm;
				term_q <= acc.term;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_in.line_end |=> mode_q == MODE_IDLE && seen_q == '0 && !tm_q && !term_q)
		else $error("line state not cleared after line end");

	assert property (@(posedge clk) disable iff (!arst_n)
		tm_q |-> seen_q >= SEEN_W'(TOKEN_LIMIT))
		else $error("discard flag set below the token limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("bundle pushed into a full queue");

endmodule

/* rtl/core/clt_fifo.sv */
// short queue of result bundles between the front and back ends
// depends on clt_pkg
module clt_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clt_pkg::bundle_t push_data,
	input  logic             pop,
	output clt_pkg::bundle_t pop_data,
	output clt_pkg::q_stat_t q_stat
);
	import clt_pkg::*;

	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	bundle_t           slot_q [QDEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (cnt_q == CNT_W'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_data     = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (do_pop) rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QDEPTH))
		else $error("queue fill count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> !q_stat.empty)
		else $error("queue empty right after a push");

endmodule

/* rtl/core/clt_back.sv */
// back end: walks the head bundle and hands out one result per beat
// through a registered output stage; depends on clt_pkg and clt_res_if
module clt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  clt_pkg::bundle_t head,
	input  clt_pkg::q_stat_t q_stat,
	output logic             pop,
	clt_res_if.source        res_out
);
	import clt_pkg::*;

	logic [1:0] sel_q;
	logic       vld_q;
	res_t       res_q;
	logic       load;
	logic       take;

	assign load = !vld_q || res_out.ready;
	assign take = load && !q_stat.empty;
	assign pop  = take && (sel_q == head.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			sel_q <= '0;
		end else begin
			if (load) vld_q <= !q_stat.empty;
			if (take) sel_q <= pop ? 2'd0 : sel_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= head.res[sel_q];
	end

	assign res_out.valid          = vld_q;
	assign res_out.result_kind    = res_q.kind;
	assign res_out.token_byte     = res_q.tbyte;
	assign res_out.token_index    = res_q.idx;
	assign res_out.char_position  = res_q.pos;
	assign res_out.token_count    = res_q.count;
	assign res_out.line_discarded = res_q.disc;
	assign res_out.last_of_run    = res_q.last;

	// partway through a bundle its entry must still sit at the head
	assert property (@(posedge clk) disable iff (!arst_n)
		sel_q != 2'd0 |-> !q_stat.empty)
		else $error("bundle left the queue before all results were sent");

endmodule

/* rtl/core/command_line_tokenizer.sv */
// top level of the command line tokenizer
// depends on clt_pkg, clt_if, clt_front, clt_fifo and clt_back
//
// Takes a command line one byte per beat and returns token characters, token ends and
// one line-done result per line. The lexer accepts a byte in every cycle in which its
// four-entry bundle queue has room; each byte turns into zero to four results, which
// the output stage sends one per cycle while the sink is ready. The queue absorbs
// bursts of multi-result bytes. When the queue and the output register are empty, the
// first result of a byte is written into a queue slot and then into the output register
// before it is presented. Results leave from a register, so a stalled sink does not stop
// byte intake until the queue fills.
// There is no start-up sweep; the block takes bytes right after reset.
module command_line_tokenizer #(
	parameter int unsigned MAX_TOKEN_LEN = clt_pkg::DEF_MAX_TOKEN_LEN,
	parameter int unsigned TOKEN_LIMIT   = clt_pkg::DEF_TOKEN_LIMIT
) (
	input  logic      clk,
	input  logic      arst_n,
	clt_line_if.sink  line_in,
	clt_res_if.source res_out
);
	import clt_pkg::*;

	bundle_t push_data;
	bundle_t head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	clt_front #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.TOKEN_LIMIT   (TOKEN_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_in   (line_in),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	clt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.q_stat    (q_stat)
	);

	clt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.res_out (res_out)
	);

endmodule

/* tb/testbench.sv */
// testbench of command_line_tokenizer: random and directed command lines, with
// tokens predicted per byte and checked field by field
// depends on clt_pkg, clt_if and the tokenizer rtl
`timescale 1ns / 100ps

module testbench;
	import clt_pkg::*;

	localparam int unsigned MAX_LEN      = DEF_MAX_TOKEN_LEN;
	localparam int unsigned TOK_LIMIT    = DEF_TOKEN_LIMIT;
	localparam int          ITEM_TARGET  = 210;
	localparam int          QUIET_TAIL   = 40;
	localparam int          HOLD_AT      = 60;
	localparam int          HOLD_CYCLES  = 200;
	localparam int          WATCHDOG     = 1000;
	localparam int          TAIL_CYCLES  = 20;
	localparam logic [13*8-1:0] SEP_CHARS = "()[]=,<>|&#^%";

	typedef struct packed {
		logic [7:0] ch;
		logic       le;
		logic       wait_drain;
	} line_item_t;

	logic clk;
	logic arst_n;

	clt_line_if line_bus ();
	clt_res_if  res_bus ();

	command_line_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line_in(line_bus),
		.res_out(res_bus)
	);

	line_item_t  stim_bytes[$];
	logic [7:0]  line_buf[$];
	res_t        due_results[$];
	res_t        byte_results[$];
	line_item_t  nxt;

	// tokenizer state as predicted
	logic [1:0]  lex_state;
	int unsigned tok_len;
	int unsigned tok_count;
	bit          limit_hit;
	bit          line_stopped;

	int errors;
	int sent_cnt;
	int recv_cnt;
	int gap_left;
	int stall_left;
	int hold_left;
	bit hold_done;
	bit quiet;
	bit drained;
	int idle_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit is_separator(logic [7:0] c);
		for (int i = 0; i < 13; i++)
			if (SEP_CHARS[i*8 +: 8] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic [7:0] sep_char();
		return SEP_CHARS[$urandom_range(0, 12)*8 +: 8];
	endfunction

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h61, 8'h7a));
		do
			c = 8'($urandom_range(1, 255));
		while (is_blank(c) || is_separator(c) || c == CH_QUOTE);
		return c;
	endfunction

	// ---- prediction ----

	function automatic void add_result(logic [1:0] kind, logic [7:0] ch, int unsigned idx,
		int unsigned pos, int unsigned count, bit disc);
		res_t r;
		r.kind  = kind;
		r.tbyte = ch;
		r.idx   = idx[5:0];
		r.pos   = pos[6:0];
		r.count = count[5:0];
		r.disc  = disc;
		r.last  = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void emit_token_char(logic [7:0] ch);
		add_result(K_CHAR, ch, tok_count, tok_len, 0, 1'b0);
		if (tok_len < 255)
			tok_len++;
	endfunction

	function automatic void close_token();
		add_result(K_END, 8'd0, tok_count, tok_len, 0, 1'b0);
		if (tok_count < 255)
			tok_count++;
		tok_len   = 0;
		lex_state = MODE_IDLE;
		if (tok_count >= TOK_LIMIT)
			limit_hit = 1'b1;
	endfunction

	function automatic void split_if_full();
		if (tok_len >= MAX_LEN)
			close_token();
	endfunction

	function automatic void open_token(logic [7:0] ch);
		if (is_blank(ch))
			return;
		if (is_separator(ch)) begin
			emit_token_char(ch);
			close_token();
			return;
		end
		emit_token_char(ch);
		lex_state = (ch == CH_QUOTE) ? MODE_QUOTE : MODE_WORD;
		split_if_full();
	endfunction

	function automatic void clear_line_state();
		lex_state    = MODE_IDLE;
		tok_len      = 0;
		tok_count    = 0;
		limit_hit    = 1'b0;
		line_stopped = 1'b0;
	endfunction

	function automatic void predict_tokens(logic [7:0] ch, logic le);
		byte_results.delete();
		if (!limit_hit && !line_stopped) begin
			if (ch == CH_NUL) begin
				if (lex_state != MODE_IDLE)
					close_token();
				line_stopped = 1'b1;
			end else if (lex_state == MODE_QUOTE) begin
				emit_token_char(ch);
				if (ch == CH_QUOTE)
					close_token();
				else
					split_if_full();
			end else if (lex_state == MODE_WORD) begin
				if (is_blank(ch)) begin
					close_token();
				end else if (is_separator(ch)) begin
					close_token();
					if (!limit_hit)
						open_token(ch);
				end else begin
					emit_token_char(ch);
					split_if_full();
				end
			end else begin
				open_token(ch);
			end
		end
		if (le) begin
			if (lex_state != MODE_IDLE && !limit_hit)
				close_token();
			add_result(K_LINE, 8'd0, 0, 0, limit_hit ? 0 : tok_count, limit_hit);
			clear_line_state();
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size()-1].last = 1'b1;
		foreach (byte_results[i])
			due_results.push_back(byte_results[i]);
	endfunction

	// ---- stimulus building ----

	task automatic flush_line(input bit drain_first);
		line_item_t it;
		foreach (line_buf[i]) begin
			it.ch         = line_buf[i];
			it.le         = (i == line_buf.size() - 1);
			it.wait_drain = drain_first && (i == 0);
			stim_bytes.push_back(it);
		end
		line_buf.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic gen_line(input bit noisy);
		int pieces;
		pieces = $urandom_range(1, 8);
		if (noisy) begin
			repeat (pieces) line_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 3))
					line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
				2, 3, 4: repeat ($urandom_range(1, 6)) line_buf.push_back(word_char());
				5, 6: line_buf.push_back(sep_char());
				7: begin
					line_buf.push_back(CH_QUOTE);
					repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(1, 255)));
					if ($urandom_range(0, 3) != 0)
						line_buf.push_back(CH_QUOTE);
				end
				8: line_buf.push_back(8'($urandom_range(0, 255)));
				default: line_buf.push_back($urandom_range(0, 3) == 0 ? CH_NUL : word_char());
			endcase
		end
	endtask

	// ---- sender ----

	always @(negedge clk)
		drained <= (due_results.size() == 0);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bus.valid    <= 1'b0;
			line_bus.in_byte  <= 8'd0;
			line_bus.line_end <= 1'b0;
			gap_left          <= 0;
			sent_cnt          <= 0;
			quiet             <= 1'b0;
		end else begin
			if (line_bus.valid && line_bus.ready) begin
				predict_tokens(line_bus.in_byte, line_bus.line_end);
				sent_cnt <= sent_cnt + 1;
			end
			quiet <= (stim_bytes.size() < QUIET_TAIL);
			if (!line_bus.valid || line_bus.ready) begin
				if (gap_left != 0) begin
					gap_left       <= gap_left - 1;
					line_bus.valid <= 1'b0;
				end else if (stim_bytes.size() == 0) begin
					line_bus.valid <= 1'b0;
				end else if (stim_bytes[0].wait_drain &&
					(!drained || (line_bus.valid && line_bus.ready))) begin
					// pause the line until every pending result is out
					line_bus.valid <= 1'b0;
				end else if (!quiet && (sent_cnt % 128) < 96 && $urandom_range(0, 5) == 0) begin
					gap_left       <= $urandom_range(0, 10);
					line_bus.valid <= 1'b0;
				end else begin
					nxt                = stim_bytes.pop_front();
					line_bus.valid    <= 1'b1;
					line_bus.in_byte  <= nxt.ch;
					line_bus.line_end <= nxt.le;
				end
			end
		end
	end

	// ---- receiver ----

	// one long hold-off on the result side so the bundle queue fills up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_cnt >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic compare_field(input string fname, input int unsigned want,
		input int unsigned seen);
		if (want != seen) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
			errors++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (due_results.size() == 0) begin
			$display("%0t: result with nothing expected, actual kind %0d byte %0d", $time,
				res_bus.result_kind, res_bus.token_byte);
			errors++;
			return;
		end
		want = due_results.pop_front();
		compare_field("result_kind", want.kind, res_bus.result_kind);
		compare_field("token_byte", want.tbyte, res_bus.token_byte);
		compare_field("token_index", want.idx, res_bus.token_index);
		compare_field("char_position", want.pos, res_bus.char_position);
		compare_field("token_count", want.count, res_bus.token_count);
		compare_field("line_discarded", want.disc, res_bus.line_discarded);
		compare_field("last_of_run", want.last, res_bus.last_of_run);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			stall_left    <= 0;
			recv_cnt      <= 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				check_result();
				recv_cnt <= recv_cnt + 1;
			end
			if (hold_left != 0) begin
				res_bus.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left    <= stall_left - 1;
				res_bus.ready <= 1'b0;
			end else if (!quiet && (recv_cnt % 128) >= 32 && $urandom_range(0, 4) == 0) begin
				stall_left    <= $urandom_range(0, 10);
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// ---- watchdog ----

	always @(posedge clk) begin
		if ((line_bus.valid && line_bus.ready) || (res_bus.valid && res_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG) begin
			$display("%0t: no beat for %0d cycles", $time, WATCHDOG);
			$display("command_line_tokenizer verification failed");
			$finish;
		end
	end

	// ---- stimulus and end of run ----

	initial begin
		int line_no;
		int byte_total;

		line_bus.valid    = 1'b0;
		line_bus.in_byte  = 8'd0;
		line_bus.line_end = 1'b0;
		res_bus.ready     = 1'b0;
		arst_n            = 1'b0;
		errors            = 0;
		idle_cycles       = 0;
		drained           = 1'b1;
		clear_line_state();

		// directed lines
		add_text("a");
		flush_line(1'b0);
		add_text("\t ab()[]=,<>|&#^%");
		flush_line(1'b0);
		// quote inside a word, closed quote, unterminated quote at line end
		add_text("c\"d \"e f\"\"g");
		flush_line(1'b0);
		// extreme bytes in a word, then a zero byte ends parsing
		line_buf.push_back(8'hff);
		line_buf.push_back(8'h80);
		line_buf.push_back(CH_NUL);
		line_buf.push_back(8'h7a);
		flush_line(1'b0);
		line_buf.push_back(CH_NUL);
		flush_line(1'b0);

		// every byte counts toward the total, the long lines included
		line_no    = 0;
		byte_total = stim_bytes.size();
		while (byte_total < ITEM_TARGET || line_no < 5) begin
			case (line_no)
				1: begin
					// word longer than the token cap
					repeat (MAX_LEN + 1) line_buf.push_back(word_char());
					add_text(" (");
				end
				3: begin
					// limit reached on a word closed by a separator
					repeat (TOK_LIMIT - 1) line_buf.push_back(8'h28);
					add_text("ab(cd");
				end
				4: begin
					line_buf.push_back(CH_QUOTE);
					repeat (MAX_LEN)
						line_buf.push_back($urandom_range(0, 4) == 0 ? CH_SPACE : word_char());
				end
				default: begin
					gen_line($urandom_range(0, 9) == 0);
				end
			endcase
			byte_total += line_buf.size();
			flush_line(line_no == 2);
			line_no++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stim_bytes.size() != 0 || line_bus.valid || due_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("command_line_tokenizer verification clean");
		else
			$display("command_line_tokenizer verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/clt_pkg.sv
rtl/core/clt_if.sv
rtl/core/clt_front.sv
rtl/core/clt_fifo.sv
rtl/core/clt_back.sv
rtl/core/command_line_tokenizer.sv
tb/testbench.sv
